>>> rtl/utcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utcl_pkg;

    localparam int MIN_PER_DAY = 1440;

    // Reciprocal multipliers, each checked to give the exact floor over the value range in use.
    localparam logic [25:0] RECIP_100 = 26'd5243;   // x / 100 = (x * RECIP_100) >> 19
    localparam logic [29:0] RECIP_7   = 30'd74899;  // x / 7   = (x * RECIP_7) >> 19
    localparam logic [20:0] RECIP_60  = 21'd1093;   // x / 60  = (x * RECIP_60) >> 16

    localparam logic [13:0] YEAR_MIN = 14'd1;
    localparam logic [13:0] YEAR_MAX = 14'd9998;

    // Day index, counted from March 1, of the first of October and of November.
    localparam logic [8:0] OCT1_IDX = 9'd214;
    localparam logic [8:0] NOV1_IDX = 9'd245;

    typedef enum logic [1:0] {
        RULE_NONE = 2'd0,
        RULE_US   = 2'd1,
        RULE_EU   = 2'd2,
        RULE_RSVD = 2'd3
    } rule_t;

    typedef enum logic [1:0] {
        REG_STD_OFFSET = 2'd0,
        REG_DST_OFFSET = 2'd1,
        REG_DST_RULE   = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [10:0] std_offset;
        logic signed [10:0] dst_offset;
        rule_t              rule;
    } cfg_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [10:0] hm;
        logic        leap;
    } date_t;

    // Calendar front end result: clamped date plus weekday arithmetic in flight.
    typedef struct packed {
        date_t             date;
        logic signed [9:0] rel;
        logic [13:0]       wsum;
        logic [29:0]       wprod;
    } prep_t;

    // Rule stage result: shifted local date, minute of day and the chosen offset.
    typedef struct packed {
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [10:0]        mod;
        logic signed [10:0] offset;
        logic               dst;
    } local_t;

    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] len;
        begin
            unique case (mo)
                4'd2:                      len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Days from March 1 of the same year to the first of the month; negative for January
    // and February.
    function automatic logic signed [9:0] month_base(input logic [3:0] mo, input logic leap);
        logic signed [9:0] base;
        begin
            unique case (mo)
                4'd1:    base = leap ? -10'sd60 : -10'sd59;
                4'd2:    base = leap ? -10'sd29 : -10'sd28;
                4'd3:    base = 10'sd0;
                4'd4:    base = 10'sd31;
                4'd5:    base = 10'sd61;
                4'd6:    base = 10'sd92;
                4'd7:    base = 10'sd122;
                4'd8:    base = 10'sd153;
                4'd9:    base = 10'sd184;
                4'd10:   base = 10'sd214;
                4'd11:   base = 10'sd245;
                default: base = 10'sd275;
            endcase
            return base;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/utcl_prep.sv
`timescale 1ns / 1ps
`default_nettype none

// Input clamping, leap year, day index counted from March 1 and the weekday sum.
module utcl_prep (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [13:0]     utc_year,
    input  wire logic [3:0]      utc_month,
    input  wire logic [4:0]      utc_day,
    input  wire logic [4:0]      utc_hour,
    input  wire logic [5:0]      utc_minute,
    output logic                 prep_valid,
    output utcl_pkg::prep_t      prep
);
    import utcl_pkg::*;

    logic        v1_reg;
    logic [13:0] y1_reg;
    logic [3:0]  mo1_reg;
    logic [4:0]  d1_reg;
    logic [4:0]  h1_reg;
    logic [5:0]  mi1_reg;
    logic [25:0] p100_reg;
    logic [23:0] p400_reg;
    logic        v2_reg;
    prep_t       s2_reg;

    logic [13:0] y_c;
    logic [3:0]  mo_c;
    logic [4:0]  h_c;
    logic [5:0]  mi_c;
    logic [6:0]  q100;
    logic [4:0]  q400;
    logic        leap;
    logic [4:0]  ml;
    logic [4:0]  d_c;
    prep_t       s2_next;

    always_comb
    begin
        y_c  = (utc_year < YEAR_MIN) ? YEAR_MIN : ((utc_year > YEAR_MAX) ? YEAR_MAX : utc_year);
        mo_c = (utc_month == 4'd0) ? 4'd1 : ((utc_month > 4'd12) ? 4'd12 : utc_month);
        h_c  = (utc_hour > 5'd23) ? 5'd23 : utc_hour;
        mi_c = (utc_minute > 6'd59) ? 6'd59 : utc_minute;
    end

    always_comb
    begin
        q100 = p100_reg[25:19];
        q400 = p400_reg[23:19];
        leap = (y1_reg[1:0] == 2'd0)
               && ((y1_reg != 14'(q100) * 14'd100) || (q100[1:0] == 2'd0));
        ml   = month_len(mo1_reg, leap);
        d_c  = (d1_reg == 5'd0) ? 5'd1 : ((d1_reg > ml) ? ml : d1_reg);
        s2_next.date.year  = y1_reg;
        s2_next.date.month = mo1_reg;
        s2_next.date.day   = d_c;
        s2_next.date.hm    = 11'(h1_reg) * 11'd60 + 11'(mi1_reg);
        s2_next.date.leap  = leap;
        s2_next.rel        = month_base(mo1_reg, leap) + $signed({5'b0, d_c}) - 10'sd1;
        // March 1 weekday sum: y + y/4 - y/100 + y/400 + 3.
        s2_next.wsum       = y1_reg + 14'(y1_reg >> 2) - 14'(q100) + 14'(q400) + 14'd3;
        s2_next.wprod      = 30'(s2_next.wsum) * RECIP_7;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg   <= y_c;
            mo1_reg  <= mo_c;
            d1_reg   <= utc_day;
            h1_reg   <= h_c;
            mi1_reg  <= mi_c;
            p100_reg <= 26'(y_c) * RECIP_100;
            p400_reg <= 24'(26'(y_c >> 2) * RECIP_100);
            s2_reg   <= s2_next;
        end
    end

    assign prep_valid = v2_reg;
    assign prep       = s2_reg;

endmodule

`default_nettype wire

>>> rtl/utcl_rule.sv
`timescale 1ns / 1ps
`default_nettype none

// Daylight window in minutes from March 1, the window test, and the local day shift.
module utcl_rule (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire utcl_pkg::cfg_t  cfg,
    input  wire logic            prep_valid,
    input  wire utcl_pkg::prep_t prep,
    output logic                 loc_valid,
    output utcl_pkg::local_t     loc
);
    import utcl_pkg::*;

    logic               v3_reg;
    date_t              date3_reg;
    logic signed [20:0] tm_reg;
    logic signed [20:0] start_reg;
    logic signed [20:0] end_reg;
    logic               act_reg;
    logic               v4_reg;
    local_t             loc_reg;

    logic [10:0]        q7;
    logic [2:0]         w0;
    logic [2:0]         k;
    logic [3:0]         wa;
    logic [3:0]         wb;
    logic [8:0]         sidx;
    logic [8:0]         eidx;
    logic signed [20:0] sadj;
    logic signed [20:0] eadj;
    logic signed [20:0] tm_next;
    logic signed [20:0] start_next;
    logic signed [20:0] end_next;

    logic               in_win;
    logic signed [10:0] off;
    logic signed [12:0] lm;
    logic [4:0]         ml;
    local_t             loc_next;

    always_comb
    begin
        q7 = prep.wprod[29:19];
        w0 = 3'(prep.wsum - 14'(q7) * 14'd7);
        k  = (w0 == 3'd0) ? 3'd0 : 3'(4'd7 - 4'(w0));
        wa = 4'(w0) + 4'd2;
        wa = (wa >= 4'd7) ? wa - 4'd7 : wa;
        wb = 4'(w0) + 4'd6;
        wb = (wb >= 4'd7) ? wb - 4'd7 : wb;
        if (cfg.rule == RULE_US)
        begin
            sidx = 9'd7 + 9'(k);
            eidx = NOV1_IDX + 9'(k);
            sadj = 21'sd120 - {{10{cfg.std_offset[10]}}, cfg.std_offset};
            eadj = 21'sd120 - {{10{cfg.dst_offset[10]}}, cfg.dst_offset};
        end
        else
        begin
            sidx = 9'd30 - 9'(wa);
            eidx = OCT1_IDX + 9'd30 - 9'(wb);
            sadj = 21'sd60;
            eadj = 21'sd60;
        end
        tm_next    = {{11{prep.rel[9]}}, prep.rel} * 21'sd1440
                     + $signed({10'b0, prep.date.hm});
        start_next = $signed({12'b0, sidx}) * 21'sd1440 + sadj;
        end_next   = $signed({12'b0, eidx}) * 21'sd1440 + eadj;
    end

    always_comb
    begin
        in_win = act_reg && (tm_reg >= start_reg) && (tm_reg < end_reg);
        off    = in_win ? cfg.dst_offset : cfg.std_offset;
        lm     = $signed({2'b0, date3_reg.hm}) + {{2{off[10]}}, off};
        ml     = month_len(date3_reg.month, date3_reg.leap);
        loc_next.year   = date3_reg.year;
        loc_next.month  = date3_reg.month;
        loc_next.day    = date3_reg.day;
        loc_next.offset = off;
        loc_next.dst    = in_win;
        loc_next.mod    = date3_reg.hm;
        if (lm < 13'sd0)
        begin
            loc_next.mod = 11'(lm + 13'sd1440);
            if (date3_reg.day > 5'd1)
            begin
                loc_next.day = date3_reg.day - 5'd1;
            end
            else if (date3_reg.month == 4'd1)
            begin
                loc_next.year  = date3_reg.year - 14'd1;
                loc_next.month = 4'd12;
                loc_next.day   = 5'd31;
            end
            else
            begin
                loc_next.month = date3_reg.month - 4'd1;
                loc_next.day   = month_len(date3_reg.month - 4'd1, date3_reg.leap);
            end
        end
        else if (lm >= 13'sd1440)
        begin
            loc_next.mod = 11'(lm - 13'sd1440);
            if (date3_reg.day < ml)
            begin
                loc_next.day = date3_reg.day + 5'd1;
            end
            else if (date3_reg.month == 4'd12)
            begin
                loc_next.year  = date3_reg.year + 14'd1;
                loc_next.month = 4'd1;
                loc_next.day   = 5'd1;
            end
            else
            begin
                loc_next.month = date3_reg.month + 4'd1;
                loc_next.day   = 5'd1;
            end
        end
        else
        begin
            loc_next.mod = 11'(lm);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= prep_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            date3_reg <= prep.date;
            tm_reg    <= tm_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            act_reg   <= (cfg.rule == RULE_US) || (cfg.rule == RULE_EU);
            loc_reg   <= loc_next;
        end
    end

    assign loc_valid = v4_reg;
    assign loc       = loc_reg;

endmodule

`default_nettype wire

>>> rtl/utc_to_local_time_dst.sv
`timescale 1ns / 1ps
`default_nettype none

// UTC to local civil time with US and EU daylight rules. Each word on the input channel is a
// UTC date and time; the block returns the local date and time, the offset in minutes that was
// applied and a flag that is set when the daylight offset was used. Out-of-range input fields
// are clamped (year 1..9998, month 1..12, day 1..month length, hour 23, minute 59). The
// datapath is a five-stage pipeline: clamping and reciprocal multiplies, leap year and weekday
// sum, daylight window bounds, window test and day shift, then hour and minute split into the
// output register. A word is accepted every cycle while the pipeline advances;
// the whole pipeline holds when the output word is not taken. Registers sit on an APB port at
// byte addresses 0 (standard offset), 4 (daylight offset) and 8 (rule: 0 none, 1 US, 2 EU,
// 3 treated as none); they must only be written while no word is in flight.
module utc_to_local_time_dst (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [13:0]        utc_year,
    input  wire logic [3:0]         utc_month,
    input  wire logic [4:0]         utc_day,
    input  wire logic [4:0]         utc_hour,
    input  wire logic [5:0]         utc_minute,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [13:0]             local_year,
    output logic [3:0]              local_month,
    output logic [4:0]              local_day,
    output logic [4:0]              local_hour,
    output logic [5:0]              local_minute,
    output logic signed [10:0]      applied_offset,
    output logic                    dst_active
);
    import utcl_pkg::*;

    cfg_t        cfg_reg;
    logic        en;
    logic        prep_valid;
    prep_t       prep;
    logic        loc_valid;
    local_t      loc;
    logic        out_valid_reg;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic signed [10:0] offset_reg;
    logic        dst_reg;
    logic [20:0] hprod;
    logic [4:0]  hour_next;
    logic        cfg_wr;
    reg_idx_t    widx;

    // The whole pipeline advances together unless the output word is stalled.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.std_offset <= 11'sd0;
            cfg_reg.dst_offset <= 11'sd0;
            cfg_reg.rule       <= RULE_NONE;
        end
        else if (cfg_wr)
        begin
            unique case (widx)
                REG_STD_OFFSET: cfg_reg.std_offset <= $signed(pwdata[10:0]);
                REG_DST_OFFSET: cfg_reg.dst_offset <= $signed(pwdata[10:0]);
                REG_DST_RULE:   cfg_reg.rule       <= rule_t'(pwdata[1:0]);
                REG_UNUSED:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_STD_OFFSET: prdata = {{21{cfg_reg.std_offset[10]}}, cfg_reg.std_offset};
            REG_DST_OFFSET: prdata = {{21{cfg_reg.dst_offset[10]}}, cfg_reg.dst_offset};
            REG_DST_RULE:   prdata = {30'b0, cfg_reg.rule};
            REG_UNUSED:     prdata = 32'b0;
        endcase
    end

    utcl_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .utc_year   (utc_year),
        .utc_month  (utc_month),
        .utc_day    (utc_day),
        .utc_hour   (utc_hour),
        .utc_minute (utc_minute),
        .prep_valid (prep_valid),
        .prep       (prep)
    );

    utcl_rule u_rule (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg_reg),
        .prep_valid (prep_valid),
        .prep       (prep),
        .loc_valid  (loc_valid),
        .loc        (loc)
    );

    // Final stage: split the minute of the day into hour and minute.
    assign hprod     = 21'(loc.mod) * RECIP_60;
    assign hour_next = hprod[20:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= loc_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year_reg   <= loc.year;
            month_reg  <= loc.month;
            day_reg    <= loc.day;
            hour_reg   <= hour_next;
            minute_reg <= 6'(loc.mod - 11'(hour_next) * 11'd60);
            offset_reg <= loc.offset;
            dst_reg    <= loc.dst;
        end
    end

    assign out_valid      = out_valid_reg;
    assign local_year     = year_reg;
    assign local_month    = month_reg;
    assign local_day      = day_reg;
    assign local_hour     = hour_reg;
    assign local_minute   = minute_reg;
    assign applied_offset = offset_reg;
    assign dst_active     = dst_reg;

    // Daylight time can only be flagged under one of the two daylight rules.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dst_active |-> (cfg_reg.rule == RULE_US) || (cfg_reg.rule == RULE_EU))
        else $error("daylight flag set without a daylight rule");

    // The applied offset is always the register picked by the daylight flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> applied_offset == (dst_active ? cfg_reg.dst_offset : cfg_reg.std_offset))
        else $error("applied offset does not match the selected register");

    // The hour and minute split stays in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (local_hour < 5'd24) && (local_minute < 6'd60))
        else $error("local time of day out of range");

endmodule

`default_nettype wire
